// ----- hw/rtl/hrt_pkg.sv -----
`default_nettype none

package hrt_pkg;

  // Header size limit (bytes) used as the top-level default
  localparam int unsigned HrtMaxHeaderBytes = 4096;

  // Widths of the result fields
  localparam int unsigned KindW = 3;
  localparam int unsigned OffW  = 12;

  // Token kinds
  typedef enum logic [KindW-1:0] {
    KIND_VERSION   = 3'd0,
    KIND_STATUS    = 3'd1,
    KIND_REASON    = 3'd2,
    KIND_NAME      = 3'd3,
    KIND_VALUE     = 3'd4,
    KIND_DONE      = 3'd5,
    KIND_BAD_START = 3'd6,
    KIND_MALFORMED = 3'd7
  } kind_e;

  // Characters the parser cares about
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChNul   = 8'h00;

  // One result entry
  typedef struct packed {
    logic            last;
    logic [OffW-1:0] len;
    logic [OffW-1:0] start;
    kind_e           kind;
  } res_t;

  // Expected leading text "HTTP"
  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h48;
      2'd1:    ch = 8'h54;
      2'd2:    ch = 8'h54;
      default: ch = 8'h50;
    endcase
    return ch;
  endfunction

  // Space, TAB, LF, VT, FF (CR is handled separately)
  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0b) || (b == 8'h0c);
  endfunction

  function automatic res_t mk_res(input kind_e kind, input logic [11:0] start,
                                  input logic [11:0] len);
    res_t r;
    r.kind  = kind;
    r.start = start;
    r.len   = len;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/http_response_header_tokenizer.sv -----
// Results are written to the queue when their byte is taken and leave it in order.
// Throughput: one byte per cycle while s_axis_tready is high; a byte yields zero to
// two results, drained one per cycle (while m_axis_tready is high) through a single output
// port from a four-entry queue. The slave side is ready while at least two are free.
// Reset (rst_ni low, asynchronous): parser at the start of a new header, queue empty.
`default_nettype none

module http_response_header_tokenizer
  import hrt_pkg::*;
#(
  parameter int unsigned MaxHeaderBytes = HrtMaxHeaderBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  // master side
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // [2:0] token_kind, [14:3] token_start,
                                           // [26:15] token_length, [31:27] zero
  output      logic        m_axis_tlast    // last_result
);

  localparam int unsigned PosW = $clog2(MaxHeaderBytes + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MaxHeaderBytes);

  // Parse phases
  localparam logic [3:0] PH_VER      = 4'd0;
  localparam logic [3:0] PH_SKIP1    = 4'd1;
  localparam logic [3:0] PH_STATUS   = 4'd2;
  localparam logic [3:0] PH_SKIP2    = 4'd3;
  localparam logic [3:0] PH_REASON   = 4'd4;
  localparam logic [3:0] PH_LINE     = 4'd5;
  localparam logic [3:0] PH_NAME     = 4'd6;
  localparam logic [3:0] PH_SKIPV    = 4'd7;
  localparam logic [3:0] PH_VALUE    = 4'd8;
  localparam logic [3:0] PH_FINAL_LF = 4'd9;

  // Parser state
  logic [3:0]      phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] tok_q, tok_d;
  logic [2:0]      pmc_q, pmc_d;
  logic            lfp_q, lfp_d;
  logic            fin_q, fin_d;

  // Result queue
  res_t       fifo_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;

  logic       s_acc, m_pop;
  logic [7:0] b;

  // Candidate results: from the byte itself, the value flush at end, the end status
  logic       tk_v, ev_v, ef_v;
  res_t       tk_r, ev_r, ef_r;
  res_t       res0, res1;
  logic [1:0] n_res;

  // Working copies during the byte
  logic [3:0]      ph;
  logic [PosW-1:0] pos, tok, end_off;
  logic [2:0]      pmc;
  logic            lfp, fin;

  assign b     = s_axis_tdata;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_pop = m_axis_tvalid && m_axis_tready;

  // Per-byte parse step
  always_comb begin
    // a finished run restarts from fresh state
    ph      = fin_q ? PH_VER : phase_q;
    pos     = fin_q ? '0 : pos_q;
    tok     = fin_q ? '0 : tok_q;
    pmc     = fin_q ? 3'd0 : pmc_q;
    lfp     = fin_q ? 1'b0 : lfp_q;
    fin     = 1'b0;
    tk_v    = 1'b0;
    ev_v    = 1'b0;
    ef_v    = 1'b0;
    tk_r    = mk_res(KIND_DONE, '0, '0);
    ev_r    = mk_res(KIND_DONE, '0, '0);
    ef_r    = mk_res(KIND_DONE, '0, '0);
    end_off = pos;

    if (b != ChNul) begin
      if (pos >= PosMax) begin
        tk_v = 1'b1;
        tk_r = mk_res(KIND_MALFORMED, 12'(pos), '0);
        fin  = 1'b1;
      end else if (lfp) begin
        lfp = 1'b0;
        if (b != ChLf) begin
          tk_v = 1'b1;
          tk_r = mk_res(KIND_MALFORMED, 12'(pos), '0);
          fin  = 1'b1;
        end else if (ph == PH_FINAL_LF) begin
          tk_v = 1'b1;
          tk_r = mk_res(KIND_DONE, 12'(pos), '0);
          fin  = 1'b1;
        end
      end else begin
        unique case (ph)
          PH_VER: begin
            if (!pmc[2]) begin
              if (b != prefix_char(pmc[1:0])) begin
                tk_v = 1'b1;
                tk_r = mk_res(KIND_BAD_START, 12'(pos), '0);
                fin  = 1'b1;
              end else begin
                pmc = pmc + 3'd1;
              end
            end else if (b == ChCr) begin
              tk_v = 1'b1;
              tk_r = mk_res(KIND_VERSION, '0, 12'(pos));
              ph   = PH_LINE;
              lfp  = 1'b1;
            end else if (is_ws(b)) begin
              tk_v = 1'b1;
              tk_r = mk_res(KIND_VERSION, '0, 12'(pos));
              ph   = PH_SKIP1;
            end
          end
          PH_SKIP1, PH_SKIP2: begin
            if (b == ChCr) begin
              ph  = PH_LINE;
              lfp = 1'b1;
            end else if (!is_ws(b)) begin
              tok = pos;
              ph  = (ph == PH_SKIP1) ? PH_STATUS : PH_REASON;
            end
          end
          PH_STATUS: begin
            if (b == ChCr || is_ws(b)) begin
              tk_v = 1'b1;
              tk_r = mk_res(KIND_STATUS, 12'(tok), 12'(pos - tok));
              if (b == ChCr) begin
                ph  = PH_LINE;
                lfp = 1'b1;
              end else begin
                ph = PH_SKIP2;
              end
            end
          end
          PH_REASON: begin
            if (b == ChCr) begin
              tk_v = 1'b1;
              tk_r = mk_res(KIND_REASON, 12'(tok), 12'(pos - tok));
              ph   = PH_LINE;
              lfp  = 1'b1;
            end
          end
          PH_LINE: begin
            if (b == ChCr) begin
              ph  = PH_FINAL_LF;
              lfp = 1'b1;
            end else if (b == ChColon) begin
              tk_v = 1'b1;
              tk_r = mk_res(KIND_NAME, 12'(pos), '0);
              ph   = PH_SKIPV;
            end else begin
              tok = pos;
              ph  = PH_NAME;
            end
          end
          PH_NAME: begin
            if (b == ChColon) begin
              tk_v = 1'b1;
              tk_r = mk_res(KIND_NAME, 12'(tok), 12'(pos - tok));
              ph   = PH_SKIPV;
            end else if (b == ChCr) begin
              tk_v = 1'b1;
              tk_r = mk_res(KIND_MALFORMED, 12'(pos), '0);
              fin  = 1'b1;
            end
          end
          PH_SKIPV: begin
            if (b == ChCr) begin
              tk_v = 1'b1;
              tk_r = mk_res(KIND_MALFORMED, 12'(pos), '0);
              fin  = 1'b1;
            end else if (!is_ws(b)) begin
              tok = pos;
              ph  = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (b == ChCr) begin
              tk_v = 1'b1;
              tk_r = mk_res(KIND_VALUE, 12'(tok), 12'(pos - tok));
              ph   = PH_LINE;
              lfp  = 1'b1;
            end
          end
          default: begin
            tk_v = 1'b1;
            tk_r = mk_res(KIND_MALFORMED, 12'(pos), '0);
            fin  = 1'b1;
          end
        endcase
      end
      end_off = (pos < PosMax) ? pos + PosW'(1) : pos;
    end

    // End of buffer: zero byte, or last flag on a byte that did not end the run
    if (b == ChNul || (!fin && s_axis_tlast)) begin
      ef_v = 1'b1;
      fin  = 1'b1;
      unique case (ph)
        PH_VER:
          ef_r = mk_res(pmc[2] ? KIND_MALFORMED : KIND_BAD_START, 12'(end_off), '0);
        PH_LINE, PH_FINAL_LF:
          ef_r = mk_res(KIND_DONE, 12'(end_off), '0);
        PH_VALUE: begin
          ev_v = 1'b1;
          ev_r = mk_res(KIND_VALUE, 12'(tok), 12'(end_off - tok));
          ef_r = mk_res(KIND_DONE, 12'(end_off), '0);
        end
        default:
          ef_r = mk_res(KIND_MALFORMED, 12'(end_off), '0);
      endcase
    end

    phase_d = ph;
    pos_d   = (b == ChNul) ? pos : end_off;
    tok_d   = tok;
    pmc_d   = pmc;
    lfp_d   = lfp;
    fin_d   = fin;
  end

  // Pack the candidates in order into at most two results
  always_comb begin
    res0  = tk_r;
    res1  = ev_r;
    n_res = 2'd0;
    priority if (tk_v) begin
      res0  = tk_r;
      res1  = ev_v ? ev_r : ef_r;
      n_res = (ev_v || ef_v) ? 2'd2 : 2'd1;
    end else if (ev_v) begin
      res0  = ev_r;
      res1  = ef_r;
      n_res = 2'd2;
    end else if (ef_v) begin
      res0  = ef_r;
      n_res = 2'd1;
    end else begin
      n_res = 2'd0;
    end
    // mark the final result of the byte
    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VER;
      pos_q   <= '0;
      tok_q   <= '0;
      pmc_q   <= 3'd0;
      lfp_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else if (s_acc) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      tok_q   <= tok_d;
      pmc_q   <= pmc_d;
      lfp_q   <= lfp_d;
      fin_q   <= fin_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (s_acc && n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (s_acc && n_res == 2'd2) begin
      fifo_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      if (s_acc) begin
        wr_ptr_q <= wr_ptr_q + n_res;
      end
      if (m_pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + (s_acc ? {1'b0, n_res} : 3'd0) - {2'b0, m_pop};
    end
  end

  assign s_axis_tready = (count_q <= 3'd2);
  assign m_axis_tvalid = (count_q != 3'd0);
  assign m_axis_tdata  = {5'b0, fifo_q[rd_ptr_q].len, fifo_q[rd_ptr_q].start,
                          fifo_q[rd_ptr_q].kind};
  assign m_axis_tlast  = fifo_q[rd_ptr_q].last;

  // Queue never holds more than its four entries
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("result queue overflow");

  // A byte flagged last always ends the run
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast) |=> fin_q)
    else $error("run not finished after last byte");

  // A zero byte always leaves at least one result queued
  a_nul_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tdata == ChNul) |=> (count_q != 3'd0 && fin_q))
    else $error("end of buffer produced no result");

endmodule

`default_nettype wire
